[hw/rtl/bdd_pkg.sv]
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared widths, codes, controller states and command/status types for the
// binary disk dilation unit.
// ----------------------------------------------------------------------------
package bdd_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 64;
  localparam int FULL_ALPHA_DEF = 4096;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int POS_W   = 9;
  localparam int ALPHA_W = 16;
  localparam int HWV_W   = 7;
  localparam int AOUT_W  = 13;
  localparam int BOX_W   = 9;
  localparam int DIM_W   = 9;
  localparam int RADF_W  = 7;
  localparam int CFGD_W  = 16;
  localparam int CFGI_W  = 2;

  // item modes
  localparam logic [MODE_W-1:0] MODE_HW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QRY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CMP = 2'd3;

  // register indexes
  localparam logic [CFGI_W-1:0] REG_THR = 2'd0;
  localparam logic [CFGI_W-1:0] REG_WID = 2'd1;
  localparam logic [CFGI_W-1:0] REG_HGT = 2'd2;
  localparam logic [CFGI_W-1:0] REG_RAD = 2'd3;

  // controller states, also the datapath command
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_CLR      = 5'd1;
  localparam logic [ST_W-1:0] S_BOX_RD   = 5'd2;
  localparam logic [ST_W-1:0] S_BOX_EX   = 5'd3;
  localparam logic [ST_W-1:0] S_BOX_CHK  = 5'd4;
  localparam logic [ST_W-1:0] S_VT_RD    = 5'd5;
  localparam logic [ST_W-1:0] S_VT_EX    = 5'd6;
  localparam logic [ST_W-1:0] S_VTT      = 5'd7;
  localparam logic [ST_W-1:0] S_VB_RD    = 5'd8;
  localparam logic [ST_W-1:0] S_VB_EX    = 5'd9;
  localparam logic [ST_W-1:0] S_VBH      = 5'd10;
  localparam logic [ST_W-1:0] S_COL_NEXT = 5'd11;
  localparam logic [ST_W-1:0] S_RF_RD    = 5'd12;
  localparam logic [ST_W-1:0] S_RF_HW    = 5'd13;
  localparam logic [ST_W-1:0] S_RF_EX    = 5'd14;
  localparam logic [ST_W-1:0] S_ROW_CHK  = 5'd15;
  localparam logic [ST_W-1:0] S_RT       = 5'd16;
  localparam logic [ST_W-1:0] S_RB_RD    = 5'd17;
  localparam logic [ST_W-1:0] S_RB_HW    = 5'd18;
  localparam logic [ST_W-1:0] S_RB_EX    = 5'd19;
  localparam logic [ST_W-1:0] S_RH       = 5'd20;
  localparam logic [ST_W-1:0] S_ROW_NEXT = 5'd21;
  localparam logic [ST_W-1:0] S_DONE     = 5'd22;

  typedef struct packed {
    logic            acc;  // input item transfer this cycle
    logic            go;   // compute item transfer this cycle
    logic [ST_W-1:0] op;   // current step
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic box_last;
    logic found;
    logic y_last;
    logic yb_last;
    logic k_last;
    logic x_last;
    logic rf_last;
    logic rb_last;
    logic any;
    logic r_zero;
    logic row_last;
  } status_t;

endpackage

[hw/rtl/binary_disk_dilation_unit.sv]
// Load and query items: one transfer per cycle, result strobed the cycle after the transfer.
// Compute item: busy while it clears the DW*DH destination frame (DW=MAX_WIDTH+2*MAX_RADIUS,
//   DH likewise), box scan, vertical passes per column, row passes (tails on covered rows).
// No item is taken while busy. With no opaque pixel the vertical and row passes are skipped.
// The receiver cannot stall; each result is on the ports for one cycle only.
// Synchronous active-low reset: configuration to defaults, box cleared; memories keep contents.
// ----------------------------------------------------------------------------
// binary_disk_dilation_unit
// Top level: binary dilation of an alpha image by a loaded disk profile.
// ----------------------------------------------------------------------------
module binary_disk_dilation_unit #(
  parameter int MAX_WIDTH  = bdd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bdd_pkg::MAX_RADIUS_DEF,
  parameter int FULL_ALPHA = bdd_pkg::FULL_ALPHA_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdd_pkg::MODE_W-1:0]         in_mode,
  input  logic [bdd_pkg::POS_W-1:0]          in_pos_x,
  input  logic [bdd_pkg::POS_W-1:0]          in_pos_y,
  input  logic signed [bdd_pkg::ALPHA_W-1:0] in_alpha_in,
  input  logic [bdd_pkg::HWV_W-1:0]          in_half_width_in,
  input  logic                               cfg_we,
  input  logic [bdd_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [bdd_pkg::CFGD_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [bdd_pkg::AOUT_W-1:0]         out_alpha_out,
  output logic                               out_box_empty,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_left,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_top,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_right,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_bottom
);
  import bdd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  bdd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .status(status), .cmd(cmd), .busy(busy)
  );

  // datapath and memories
  bdd_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS), .FULL_ALPHA(FULL_ALPHA)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_mode(in_mode), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_alpha_in(in_alpha_in), .in_half_width_in(in_half_width_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_alpha_out(out_alpha_out),
    .out_box_empty(out_box_empty), .out_box_left(out_box_left),
    .out_box_top(out_box_top), .out_box_right(out_box_right),
    .out_box_bottom(out_box_bottom)
  );

endmodule

[hw/rtl/bdd_ram.sv]
// ----------------------------------------------------------------------------
// bdd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bdd_ctrl.sv]
// ----------------------------------------------------------------------------
// bdd_ctrl
// Compute sequencer: clear, bounding scan, vertical passes per column and
// row passes per destination row.
// ----------------------------------------------------------------------------
module bdd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bdd_pkg::MODE_W-1:0]   in_mode,
  input  bdd_pkg::status_t             status,
  output bdd_pkg::cmd_t                cmd,
  output logic                         busy
);
  import bdd_pkg::*;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            acc;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  assign cmd.acc = acc;
  assign cmd.go  = acc && (in_mode == MODE_CMP);
  assign cmd.op  = state_r;

  // pick next step
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (cmd.go) state_nxt = S_CLR;
      S_CLR:      if (status.clr_last) state_nxt = S_BOX_RD;
      S_BOX_RD:   state_nxt = S_BOX_EX;
      S_BOX_EX:   state_nxt = status.box_last ? S_BOX_CHK : S_BOX_RD;
      S_BOX_CHK:  state_nxt = status.found ? S_VT_RD : S_DONE;
      S_VT_RD:    state_nxt = S_VT_EX;
      S_VT_EX: begin
        if (status.y_last) state_nxt = status.r_zero ? S_VB_RD : S_VTT;
        else               state_nxt = S_VT_RD;
      end
      S_VTT:      if (status.k_last) state_nxt = S_VB_RD;
      S_VB_RD:    state_nxt = S_VB_EX;
      S_VB_EX: begin
        if (status.yb_last) state_nxt = status.r_zero ? S_COL_NEXT : S_VBH;
        else                state_nxt = S_VB_RD;
      end
      S_VBH:      if (status.k_last) state_nxt = S_COL_NEXT;
      S_COL_NEXT: state_nxt = status.x_last ? S_RF_RD : S_VT_RD;
      S_RF_RD:    state_nxt = S_RF_HW;
      S_RF_HW:    state_nxt = S_RF_EX;
      S_RF_EX:    state_nxt = status.rf_last ? S_ROW_CHK : S_RF_RD;
      S_ROW_CHK: begin
        if (status.any) state_nxt = status.r_zero ? S_RB_RD : S_RT;
        else            state_nxt = S_ROW_NEXT;
      end
      S_RT:       if (status.k_last) state_nxt = S_RB_RD;
      S_RB_RD:    state_nxt = S_RB_HW;
      S_RB_HW:    state_nxt = S_RB_EX;
      S_RB_EX: begin
        if (status.rb_last) state_nxt = status.r_zero ? S_ROW_NEXT : S_RH;
        else                state_nxt = S_RB_RD;
      end
      S_RH:       if (status.k_last) state_nxt = S_ROW_NEXT;
      S_ROW_NEXT: state_nxt = status.row_last ? S_DONE : S_RF_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/bdd_datapath.sv]
// ----------------------------------------------------------------------------
// bdd_datapath
// Configuration, counters, the four memories and the per-step arithmetic
// of the dilation; drives the result ports.
// ----------------------------------------------------------------------------
module bdd_datapath #(
  parameter int MAX_WIDTH  = bdd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bdd_pkg::MAX_RADIUS_DEF,
  parameter int FULL_ALPHA = bdd_pkg::FULL_ALPHA_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bdd_pkg::cmd_t                      cmd,
  output bdd_pkg::status_t                   status,
  input  logic [bdd_pkg::MODE_W-1:0]         in_mode,
  input  logic [bdd_pkg::POS_W-1:0]          in_pos_x,
  input  logic [bdd_pkg::POS_W-1:0]          in_pos_y,
  input  logic signed [bdd_pkg::ALPHA_W-1:0] in_alpha_in,
  input  logic [bdd_pkg::HWV_W-1:0]          in_half_width_in,
  input  logic                               cfg_we,
  input  logic [bdd_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [bdd_pkg::CFGD_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [bdd_pkg::AOUT_W-1:0]         out_alpha_out,
  output logic                               out_box_empty,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_left,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_top,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_right,
  output logic [bdd_pkg::BOX_W-1:0]          out_box_bottom
);
  import bdd_pkg::*;

  localparam int DWID = MAX_WIDTH + 2 * MAX_RADIUS;
  localparam int DHGT = MAX_HEIGHT + 2 * MAX_RADIUS;
  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DXW  = $clog2(DWID);
  localparam int DYW  = $clog2(DHGT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HHW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int DDW  = $clog2(MAX_RADIUS + 2);
  localparam int HAW  = $clog2(MAX_RADIUS + 1);
  localparam int HCW  = HWV_W + 1;

  // configuration
  logic signed [ALPHA_W-1:0] thr_r, thr_nxt;
  logic [WW-1:0]             w_r, w_nxt;
  logic [HHW-1:0]            h_r, h_nxt;
  logic [RW-1:0]             rad_r, rad_nxt;

  // walk state
  logic [XW-1:0]         cx_r, cx_nxt;
  logic [DYW-1:0]        cy_r, cy_nxt;
  logic [DXW-1:0]        dcol_r, dcol_nxt;
  logic [RW-1:0]         ck_r, ck_nxt;
  logic [DDW-1:0]        vcnt_r, vcnt_nxt;
  logic signed [HCW-1:0] hcnt_r, hcnt_nxt;
  logic [DDW-1:0]        d_r, d_nxt;
  logic [XW-1:0]         lft_r, lft_nxt;
  logic [XW-1:0]         rmax_r, rmax_nxt;
  logic                  found_r, found_nxt;
  logic                  any_r, any_nxt;
  logic                  topv_r, topv_nxt;
  logic [DYW-1:0]        top_r, top_nxt;
  logic [DYW:0]          bot_r, bot_nxt;

  // stored box and result pipe
  logic             bx_empty_r, bx_empty_nxt;
  logic [BOX_W-1:0] bx_left_r, bx_left_nxt;
  logic [BOX_W-1:0] bx_top_r, bx_top_nxt;
  logic [BOX_W-1:0] bx_right_r, bx_right_nxt;
  logic [BOX_W-1:0] bx_bottom_r, bx_bottom_nxt;
  logic             pend_r, pend_q_r;

  // memory ports
  logic                 op_we, op_rdata;
  logic [YW+XW-1:0]     op_waddr, op_raddr;
  logic                 vd_we;
  logic [DYW+XW-1:0]    vd_waddr, vd_raddr;
  logic [DDW-1:0]       vd_wdata, vd_rdata;
  logic                 ds_we, ds_wdata, ds_rdata;
  logic [DYW+DXW-1:0]   ds_waddr, ds_raddr;
  logic                 hw_we;
  logic [HAW-1:0]       hw_waddr, hw_raddr;
  logic [HWV_W-1:0]     hw_rdata;

  // helpers
  int                    rad_i;
  logic [XW-1:0]         wl;
  logic [DYW-1:0]        hl;
  logic [DDW-1:0]        vsat, c1;
  logic signed [HCW-1:0] hdec, hnew, hw_s;
  logic                  d_in;
  logic                  qry_in;

  assign rad_i = int'(rad_r);
  assign wl    = XW'(int'(w_r) - 1);
  assign hl    = DYW'(int'(h_r) - 1);
  assign vsat  = (int'(vcnt_r) >= rad_i + 1) ? DDW'(rad_i + 1) : DDW'(int'(vcnt_r) + 1);
  assign hdec  = (hcnt_r < 0) ? hcnt_r : hcnt_r - HCW'(1);
  assign hw_s  = signed'({1'b0, hw_rdata});
  assign d_in  = (int'(d_r) <= rad_i);
  assign hnew  = (d_in && (hw_s > hdec)) ? hw_s : hdec;
  assign qry_in = (int'(in_pos_x) < DWID) && (int'(in_pos_y) < DHGT);

  // status toward the controller
  assign status.clr_last = (cy_r == DYW'(DHGT - 1)) && (dcol_r == DXW'(DWID - 1));
  assign status.box_last = (cx_r == wl) && (cy_r == hl);
  assign status.found    = found_r;
  assign status.y_last   = (cy_r == hl);
  assign status.yb_last  = (cy_r == '0);
  assign status.k_last   = (int'(ck_r) == rad_i - 1);
  assign status.x_last   = (cx_r == wl);
  assign status.rf_last  = (cx_r == rmax_r);
  assign status.rb_last  = (cx_r == lft_r);
  assign status.any      = any_r;
  assign status.r_zero   = (rad_r == '0);
  assign status.row_last = (int'(cy_r) == int'(h_r) + 2 * rad_i - 1);

  // load-side memory writes and read addresses
  assign op_we    = cmd.acc && (in_mode == MODE_PIX) &&
                    (int'(in_pos_x) < MAX_WIDTH) && (int'(in_pos_y) < MAX_HEIGHT);
  assign op_waddr = {YW'(in_pos_y), XW'(in_pos_x)};
  assign op_raddr = {YW'(cy_r), cx_r};
  assign hw_we    = cmd.acc && (in_mode == MODE_HW) && (int'(in_pos_x) <= MAX_RADIUS);
  assign hw_waddr = HAW'(in_pos_x);
  assign hw_raddr = (int'(vd_rdata) > MAX_RADIUS) ? '0 : HAW'(vd_rdata);
  assign ds_raddr = {DYW'(in_pos_y), DXW'(in_pos_x)};
  assign vd_raddr = (cmd.op == S_VB_RD) ? {DYW'(int'(cy_r) + rad_i), cx_r} : {cy_r, cx_r};

  // step arithmetic
  always_comb begin
    thr_nxt       = thr_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    rad_nxt       = rad_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dcol_nxt      = dcol_r;
    ck_nxt        = ck_r;
    vcnt_nxt      = vcnt_r;
    hcnt_nxt      = hcnt_r;
    d_nxt         = d_r;
    lft_nxt       = lft_r;
    rmax_nxt      = rmax_r;
    found_nxt     = found_r;
    any_nxt       = any_r;
    topv_nxt      = topv_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    bx_empty_nxt  = bx_empty_r;
    bx_left_nxt   = bx_left_r;
    bx_top_nxt    = bx_top_r;
    bx_right_nxt  = bx_right_r;
    bx_bottom_nxt = bx_bottom_r;
    c1            = vsat;
    vd_we         = 1'b0;
    vd_waddr      = {cy_r, cx_r};
    vd_wdata      = vsat;
    ds_we         = 1'b0;
    ds_waddr      = {cy_r, dcol_r};
    ds_wdata      = 1'b1;

    // register writes; width, height and radius saturated into range
    if (cfg_we) begin
      case (cfg_index)
        REG_THR: thr_nxt = signed'(cfg_data);
        REG_WID: begin
          if (cfg_data[DIM_W-1:0] == '0) w_nxt = WW'(1);
          else if (int'(cfg_data[DIM_W-1:0]) > MAX_WIDTH) w_nxt = WW'(MAX_WIDTH);
          else w_nxt = WW'(cfg_data[DIM_W-1:0]);
        end
        REG_HGT: begin
          if (cfg_data[DIM_W-1:0] == '0) h_nxt = HHW'(1);
          else if (int'(cfg_data[DIM_W-1:0]) > MAX_HEIGHT) h_nxt = HHW'(MAX_HEIGHT);
          else h_nxt = HHW'(cfg_data[DIM_W-1:0]);
        end
        REG_RAD: begin
          if (int'(cfg_data[RADF_W-1:0]) > MAX_RADIUS) rad_nxt = RW'(MAX_RADIUS);
          else rad_nxt = RW'(cfg_data[RADF_W-1:0]);
        end
        default: ;
      endcase
    end

    if (cmd.go) begin
      cy_nxt   = '0;
      dcol_nxt = '0;
    end

    case (cmd.op)
      // clear the whole destination frame
      S_CLR: begin
        ds_we    = 1'b1;
        ds_wdata = 1'b0;
        if (dcol_r == DXW'(DWID - 1)) begin
          dcol_nxt = '0;
          cy_nxt   = cy_r + DYW'(1);
        end else begin
          dcol_nxt = dcol_r + DXW'(1);
        end
        if (status.clr_last) begin
          cy_nxt    = '0;
          cx_nxt    = '0;
          found_nxt = 1'b0;
        end
      end
      // column extent of opaque pixels
      S_BOX_EX: begin
        if (op_rdata) begin
          found_nxt = 1'b1;
          rmax_nxt  = cx_r;
          if (!found_r) lft_nxt = cx_r;
        end
        if (cy_r == hl) begin
          cy_nxt = '0;
          cx_nxt = status.x_last ? '0 : cx_r + XW'(1);
        end else begin
          cy_nxt = cy_r + DYW'(1);
        end
        vcnt_nxt = DDW'(rad_i);
      end
      S_BOX_CHK: begin
        if (!found_r) begin
          bx_empty_nxt  = 1'b1;
          bx_left_nxt   = '0;
          bx_top_nxt    = '0;
          bx_right_nxt  = '0;
          bx_bottom_nxt = '0;
        end
      end
      // top-down distance
      S_VT_EX: begin
        c1       = op_rdata ? '0 : vsat;
        vd_we    = 1'b1;
        vd_waddr = {DYW'(int'(cy_r) + rad_i), cx_r};
        vd_wdata = c1;
        vcnt_nxt = c1;
        if (status.y_last) begin
          ck_nxt = '0;
          if (status.r_zero) vcnt_nxt = DDW'(rad_i);
        end else begin
          cy_nxt = cy_r + DYW'(1);
        end
      end
      S_VTT: begin
        vd_we    = 1'b1;
        vd_waddr = {DYW'(int'(h_r) + rad_i + int'(ck_r)), cx_r};
        vd_wdata = vsat;
        vcnt_nxt = vsat;
        ck_nxt   = ck_r + RW'(1);
        if (status.k_last) vcnt_nxt = DDW'(rad_i);
      end
      // bottom-up distance, keep the smaller
      S_VB_EX: begin
        c1       = op_rdata ? '0 : vsat;
        vd_we    = (c1 < vd_rdata);
        vd_waddr = {DYW'(int'(cy_r) + rad_i), cx_r};
        vd_wdata = c1;
        vcnt_nxt = c1;
        if (status.yb_last) ck_nxt = '0;
        else cy_nxt = cy_r - DYW'(1);
      end
      S_VBH: begin
        vd_we    = 1'b1;
        vd_waddr = {DYW'(rad_i - 1 - int'(ck_r)), cx_r};
        vd_wdata = vsat;
        vcnt_nxt = vsat;
        ck_nxt   = ck_r + RW'(1);
      end
      S_COL_NEXT: begin
        cy_nxt   = '0;
        vcnt_nxt = DDW'(rad_i);
        if (status.x_last) begin
          cx_nxt   = lft_r;
          hcnt_nxt = '0;
          any_nxt  = 1'b0;
          topv_nxt = 1'b0;
        end else begin
          cx_nxt = cx_r + XW'(1);
        end
      end
      // fetch distance, then half-width
      S_RF_HW, S_RB_HW: d_nxt = vd_rdata;
      S_RF_EX, S_RB_EX: begin
        hcnt_nxt = hnew;
        ds_we    = (hnew >= 0);
        ds_waddr = {cy_r, DXW'(int'(cx_r) + rad_i)};
        if (cmd.op == S_RF_EX) begin
          if (d_in) any_nxt = 1'b1;
          if (status.rf_last) ck_nxt = '0;
          else cx_nxt = cx_r + XW'(1);
        end else begin
          if (status.rb_last) ck_nxt = '0;
          else cx_nxt = cx_r - XW'(1);
        end
      end
      S_ROW_CHK: begin
        if (any_r) begin
          if (!topv_r) begin
            top_nxt  = cy_r;
            topv_nxt = 1'b1;
          end
          bot_nxt = {1'b0, cy_r} + (DYW+1)'(1);
          if (status.r_zero) hcnt_nxt = '0;
        end
      end
      // right tail beyond the last column
      S_RT: begin
        hcnt_nxt = hdec;
        ds_we    = (hdec >= 0);
        ds_waddr = {cy_r, DXW'(int'(rmax_r) + 1 + rad_i + int'(ck_r))};
        ck_nxt   = ck_r + RW'(1);
        if (status.k_last) hcnt_nxt = '0;
      end
      // left tail before the first column
      S_RH: begin
        hcnt_nxt = hdec;
        ds_we    = (hdec >= 0);
        ds_waddr = {cy_r, DXW'(int'(lft_r) + rad_i - 1 - int'(ck_r))};
        ck_nxt   = ck_r + RW'(1);
      end
      S_ROW_NEXT: begin
        if (status.row_last) begin
          bx_empty_nxt  = 1'b0;
          bx_left_nxt   = BOX_W'(lft_r);
          bx_right_nxt  = BOX_W'(int'(rmax_r) + 1 + 2 * rad_i);
          bx_top_nxt    = BOX_W'(top_r);
          bx_bottom_nxt = BOX_W'(bot_r);
        end else begin
          cy_nxt   = cy_r + DYW'(1);
          cx_nxt   = lft_r;
          hcnt_nxt = '0;
          any_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      w_r         <= WW'(MAX_WIDTH);
      h_r         <= HHW'(MAX_HEIGHT);
      rad_r       <= '0;
      bx_empty_r  <= 1'b1;
      bx_left_r   <= '0;
      bx_top_r    <= '0;
      bx_right_r  <= '0;
      bx_bottom_r <= '0;
      pend_r      <= 1'b0;
      pend_q_r    <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      rad_r       <= rad_nxt;
      bx_empty_r  <= bx_empty_nxt;
      bx_left_r   <= bx_left_nxt;
      bx_top_r    <= bx_top_nxt;
      bx_right_r  <= bx_right_nxt;
      bx_bottom_r <= bx_bottom_nxt;
      pend_r      <= cmd.acc && (in_mode != MODE_CMP);
      pend_q_r    <= cmd.acc && (in_mode == MODE_QRY) && qry_in;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    dcol_r  <= dcol_nxt;
    ck_r    <= ck_nxt;
    vcnt_r  <= vcnt_nxt;
    hcnt_r  <= hcnt_nxt;
    d_r     <= d_nxt;
    lft_r   <= lft_nxt;
    rmax_r  <= rmax_nxt;
    found_r <= found_nxt;
    any_r   <= any_nxt;
    topv_r  <= topv_nxt;
    top_r   <= top_nxt;
    bot_r   <= bot_nxt;
  end

  // memories
  bdd_ram #(.WIDTH(1), .DEPTH(1 << (YW + XW))) u_opaque (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(in_alpha_in > thr_r),
    .raddr(op_raddr), .rdata(op_rdata)
  );

  bdd_ram #(.WIDTH(DDW), .DEPTH(1 << (DYW + XW))) u_vdist (
    .clk(clk), .we(vd_we), .waddr(vd_waddr), .wdata(vd_wdata),
    .raddr(vd_raddr), .rdata(vd_rdata)
  );

  bdd_ram #(.WIDTH(1), .DEPTH(1 << (DYW + DXW))) u_dest (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );

  bdd_ram #(.WIDTH(HWV_W), .DEPTH(MAX_RADIUS + 1)) u_hwtab (
    .clk(clk), .we(hw_we), .waddr(hw_waddr), .wdata(in_half_width_in),
    .raddr(hw_raddr), .rdata(hw_rdata)
  );

  // result ports
  assign out_valid      = pend_r || (cmd.op == S_DONE);
  assign out_alpha_out  = (pend_q_r && ds_rdata) ? AOUT_W'(FULL_ALPHA) : '0;
  assign out_box_empty  = bx_empty_r;
  assign out_box_left   = bx_left_r;
  assign out_box_top    = bx_top_r;
  assign out_box_right  = bx_right_r;
  assign out_box_bottom = bx_bottom_r;

`ifndef SYNTHESIS
  a_no_pend_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != S_IDLE && cmd.op != S_DONE) |-> !pend_r)
    else $error("load or query result pending during compute");
  a_query_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_q_r |-> pend_r)
    else $error("query flag without pending result");
  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    bx_empty_r |-> (bx_left_r == '0 && bx_right_r == '0 &&
                    bx_top_r == '0 && bx_bottom_r == '0))
    else $error("empty box with nonzero edges");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary disk dilation unit. Phases of register
// settings load a small source image and the half-width profile, run one
// dilation each and probe the destination map, while a scoreboard class
// tracks the frame and predicts every result.
// ----------------------------------------------------------------------------

class dilation_board;
  localparam int MW = bdd_pkg::MAX_WIDTH_DEF;
  localparam int MH = bdd_pkg::MAX_HEIGHT_DEF;
  localparam int MR = bdd_pkg::MAX_RADIUS_DEF;
  localparam int DWM = MW + 2 * MR;
  localparam int DHM = MH + 2 * MR;

  typedef struct {
    logic [12:0] alpha;
    logic        empty;
    logic [8:0]  left, top, right, bottom;
  } box_result_t;

  int          thr;
  int unsigned wid, hgt, rad;
  bit          opaque[MW * MH];
  byte unsigned vdist[MW * DHM];
  bit          dmap[DWM * DHM];
  int unsigned hw_tab[MR + 1];
  int unsigned bl, bt, br, bb;
  bit          bempty;
  box_result_t awaited[$];
  int          errors;

  function void init();
    thr = 0; wid = MW; hgt = MH; rad = 0;
    bl = 0; bt = 0; br = 0; bb = 0; bempty = 1;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      bdd_pkg::REG_THR: thr = $signed(val);
      bdd_pkg::REG_WID: wid = (val[8:0] == 0) ? 1 : (val[8:0] > MW ? MW : val[8:0]);
      bdd_pkg::REG_HGT: hgt = (val[8:0] == 0) ? 1 : (val[8:0] > MH ? MH : val[8:0]);
      bdd_pkg::REG_RAD: rad = (val[6:0] > MR) ? MR : val[6:0];
      default: ;
    endcase
  endfunction

  function int unsigned sinc(int unsigned v, int unsigned cap);
    return (v >= cap) ? cap : v + 1;
  endfunction

  function int extend(int cnt, int unsigned d);
    cnt--;
    if (d <= rad && int'(hw_tab[d]) > cnt) cnt = hw_tab[d];
    return cnt;
  endfunction

  // distance to the nearest opaque pixel above and below, per column
  function void column_pass();
    int unsigned cap, cnt, idx;
    cap = rad + 1;
    for (int x = 0; x < wid; x++) begin
      cnt = rad;
      for (int y = 0; y < hgt; y++) begin
        cnt = sinc(cnt, cap);
        if (opaque[y * MW + x]) cnt = 0;
        vdist[(y + rad) * MW + x] = cnt;
      end
      for (int y = hgt + rad; y < hgt + 2 * rad; y++) begin
        cnt = sinc(cnt, cap);
        vdist[y * MW + x] = cnt;
      end
      cnt = rad;
      for (int y = hgt - 1; y >= 0; y--) begin
        idx = (y + rad) * MW + x;
        cnt = sinc(cnt, cap);
        if (opaque[y * MW + x]) cnt = 0;
        if (cnt < vdist[idx]) vdist[idx] = cnt;
      end
      for (int y = rad - 1; y >= 0; y--) begin
        cnt = sinc(cnt, cap);
        vdist[y * MW + x] = cnt;
      end
    end
  endfunction

  function void dilate();
    int unsigned dh, lo, hi, top, bot, d;
    int cnt;
    bit hit;
    dh = hgt + 2 * rad;
    lo = wid; hi = 0; top = dh; bot = 0;
    foreach (dmap[i]) dmap[i] = 0;
    for (int x = 0; x < wid; x++)
      for (int y = 0; y < hgt; y++)
        if (opaque[y * MW + x]) begin
          if (x < lo) lo = x;
          if (x + 1 > hi) hi = x + 1;
        end
    if (lo >= hi) begin
      bempty = 1; bl = 0; bt = 0; br = 0; bb = 0;
      return;
    end
    column_pass();
    // sweep each row both ways, spreading the profile width
    for (int row = 0; row < dh; row++) begin
      hit = 0;
      cnt = 0;
      for (int x = lo; x < hi; x++) begin
        d = vdist[row * MW + x];
        if (d <= rad) hit = 1;
        cnt = extend(cnt, d);
        if (cnt >= 0) dmap[row * DWM + x + rad] = 1;
      end
      if (!hit) continue;
      for (int c = hi + rad; c < hi + 2 * rad; c++) begin
        cnt--;
        if (cnt >= 0) dmap[row * DWM + c] = 1;
      end
      if (row < top) top = row;
      bot = row + 1;
      cnt = 0;
      for (int x = hi - 1; x >= int'(lo); x--) begin
        cnt = extend(cnt, vdist[row * MW + x]);
        if (cnt >= 0) dmap[row * DWM + x + rad] = 1;
      end
      for (int c = lo + rad - 1; c >= int'(lo); c--) begin
        cnt--;
        if (cnt >= 0) dmap[row * DWM + c] = 1;
      end
    end
    bempty = 0; bl = lo; br = hi + 2 * rad; bt = top; bb = bot;
  endfunction

  // update the frame for one accepted item and queue its result
  function void note_item(logic [1:0] mode, logic [8:0] px, logic [8:0] py,
                          logic signed [15:0] alpha, logic [6:0] hw);
    box_result_t res;
    res.alpha = 0;
    case (mode)
      bdd_pkg::MODE_HW:  if (px <= MR) hw_tab[px] = hw;
      bdd_pkg::MODE_PIX: if (px < MW && py < MH) opaque[py * MW + px] = (int'(alpha) > thr);
      bdd_pkg::MODE_QRY: if (px < DWM && py < DHM && dmap[py * DWM + px]) res.alpha = 4096;
      default: dilate();
    endcase
    res.empty = bempty;
    res.left = bl; res.top = bt; res.right = br; res.bottom = bb;
    awaited.push_back(res);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task check_result(logic [12:0] alpha, logic empty, logic [8:0] left,
                    logic [8:0] top, logic [8:0] right, logic [8:0] bottom);
    box_result_t e;
    if (awaited.size() == 0) begin
      report("unexpected result", 1, 0);
      return;
    end
    e = awaited.pop_front();
    if (alpha !== e.alpha) report("alpha_out", alpha, e.alpha);
    if (empty !== e.empty) report("box_empty", empty, e.empty);
    if (left !== e.left) report("box_left", left, e.left);
    if (top !== e.top) report("box_top", top, e.top);
    if (right !== e.right) report("box_right", right, e.right);
    if (bottom !== e.bottom) report("box_bottom", bottom, e.bottom);
  endtask
endclass

module tb;
  import bdd_pkg::*;

  localparam int LIMIT = 6000000;

  logic clk, rst_n, start, busy, cfg_we, out_valid, out_box_empty;
  logic [MODE_W-1:0] in_mode;
  logic [POS_W-1:0] in_pos_x, in_pos_y;
  logic signed [ALPHA_W-1:0] in_alpha_in;
  logic [HWV_W-1:0] in_half_width_in;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;
  logic [AOUT_W-1:0] out_alpha_out;
  logic [BOX_W-1:0] out_box_left, out_box_top, out_box_right, out_box_bottom;

  dilation_board board;
  int cycles;
  bit computed;
  bit burst;

  binary_disk_dilation_unit u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_alpha_out, out_box_empty, out_box_left, out_box_top,
                         out_box_right, out_box_bottom);
  end

  // hold start until the transfer, with a random gap first unless in burst
  task automatic send(logic [1:0] mode, logic [8:0] px, logic [8:0] py,
                      logic [15:0] alpha, logic [6:0] hw);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_mode <= mode; in_pos_x <= px; in_pos_y <= py;
    in_alpha_in <= alpha; in_half_width_in <= hw;
    do @(posedge clk); while (busy);
    board.note_item(mode, px, py, alpha, hw);
    if (mode == MODE_CMP) computed = 1;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] thr, logic [15:0] w, logic [15:0] h,
                            logic [15:0] r);
    logic [15:0] vals[4];
    vals = '{thr, w, h, r};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1; cfg_index <= i[1:0]; cfg_data <= vals[i];
      @(posedge clk);
      board.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 0;
  endtask

  task automatic query_frame();
    send(MODE_QRY, $urandom_range(0, board.wid + 2 * board.rad),
         $urandom_range(0, board.hgt + 2 * board.rad), $urandom, $urandom);
  endtask

  task automatic run_phase(logic [15:0] thr, logic [15:0] w, logic [15:0] h,
                           logic [15:0] r, int n_rand);
    int pick;
    drain();
    write_regs(thr, w, h, r);
    burst = $urandom_range(0, 1);
    // every pixel the dilation reads must be written first
    for (int y = 0; y < board.hgt; y++)
      for (int x = 0; x < board.wid; x++)
        send(MODE_PIX, x, y, $urandom, $urandom);
    for (int i = 0; i < n_rand; i++) begin
      if (i % 40 == 0) burst = ~burst;
      if (i == n_rand / 2 && $urandom_range(0, 1)) drain();
      pick = $urandom_range(0, 9);
      if (pick < 6)
        send(MODE_PIX, $urandom_range(0, board.wid - 1), $urandom_range(0, board.hgt - 1),
             $urandom, $urandom);
      else if (pick == 6)
        send(MODE_PIX, $urandom_range(0, 511), $urandom_range(0, 511), $urandom, $urandom);
      else if (pick == 7)
        send(MODE_HW, $urandom_range(0, 127), $urandom, $urandom, $urandom);
      else if (computed)
        send(MODE_QRY, $urandom_range(0, 511), $urandom_range(0, 511), $urandom, $urandom);
      else
        send(MODE_HW, $urandom_range(0, 64), $urandom, $urandom, $urandom);
    end
    send(MODE_CMP, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 20; i++) query_frame();
  endtask

  initial begin
    board = new();
    board.init();
    rst_n <= 0; start <= 0; cfg_we <= 0; cfg_index <= REG_THR; cfg_data <= 0;
    in_mode <= MODE_HW; in_pos_x <= 0; in_pos_y <= 0;
    in_alpha_in <= 0; in_half_width_in <= 0;
    cycles <= 0; computed = 0; burst = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // whole profile, extreme entry values first
    send(MODE_HW, 0, 0, 0, 7'd127);
    send(MODE_HW, 64, 9'h1ff, 16'hffff, 7'd0);
    for (int i = 0; i <= 64; i++) send(MODE_HW, i, 0, 0, $urandom_range(0, 64));

    // single pixel frame, zero sizes saturate to one; alpha extremes
    drain();
    write_regs(16'h8000, 16'd0, 16'd0, 16'd1);
    send(MODE_PIX, 0, 0, 16'h8000, 0);
    send(MODE_CMP, 0, 0, 0, 0);
    send(MODE_QRY, 0, 0, 0, 0);
    send(MODE_PIX, 0, 0, 16'h7fff, 0);
    send(MODE_PIX, 9'h1ff, 9'h1ff, 16'h7fff, 7'h7f);
    send(MODE_PIX, 256, 0, 16'h7fff, 0);
    send(MODE_HW, 65, 0, 0, 7'h7f);
    send(MODE_HW, 9'h1ff, 0, 0, 7'h55);
    send(MODE_CMP, 9'h1ff, 9'h1ff, 16'hffff, 7'h7f);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) send(MODE_QRY, i, j, 0, 0);
    send(MODE_QRY, 383, 383, 0, 0);
    send(MODE_QRY, 384, 0, 0, 0);
    send(MODE_QRY, 0, 384, 0, 0);
    send(MODE_QRY, 9'h1ff, 9'h1ff, 16'hffff, 7'h7f);

    run_phase(16'd0, 16'd12, 16'd9, 16'd0, 40);
    run_phase(16'h7fff, 16'd6, 16'd6, 16'd2, 30);
    run_phase(16'hff9c, 16'h01ff, 16'd1, 16'h007f, 20);
    run_phase(16'd1000, 16'd10, 16'd10, 16'd5, 40);
    run_phase(16'hfc00, 16'd8, 16'd7, 16'd3, 40);

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
